FILE: rtl/core/pem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pem_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int PIX_W      = 8;
    localparam int CX_W       = 10;
    localparam int CY_W       = 12;
    localparam int EDGE_W     = 8;
    localparam int GRAD_W     = 11;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FH_W-1:0] MAX_HEIGHT_C     = 13'd4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // floor(a / 6) == (a * 43691) >> 18 for every a below 2^16
    localparam int             ABS_W       = GRAD_W - 1;
    localparam int             RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] DIV6_RECIP = 16'd43691;
    localparam int             DIV6_SHIFT  = 18;
    localparam int             QUOT_W      = 7;
    localparam int             SQ_W        = 2 * QUOT_W;

    localparam int ROOT_IN_W  = 16;
    localparam int ROOT_STEPS = ROOT_IN_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int REM_W      = 10;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [CX_W-1:0]          center_x;
        logic [CY_W-1:0]          center_y;
        logic                     frame_end;
    } t_grad_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQR,
        BK_ROOT,
        BK_HOLD
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/core/pem_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pem_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire pem_pkg::t_grad_item          i_item,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output pem_pkg::t_grad_item               o_item,
    output logic [pem_pkg::Q_CNT_W-1:0]       o_count
);

    pem_pkg::t_grad_item               r_mem [pem_pkg::QUEUE_DEPTH];
    logic [pem_pkg::Q_PTR_W-1:0]       r_wp;
    logic [pem_pkg::Q_PTR_W-1:0]       r_rp;
    logic [pem_pkg::Q_CNT_W-1:0]       r_count;
    logic                              do_pop;

    // writer never pushes into a full queue, see full logic in front
    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + pem_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + pem_pkg::Q_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + pem_pkg::Q_CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - pem_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pem_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pem_front #(
    parameter int MAX_WIDTH = pem_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [pem_pkg::PIX_W-1:0]       i_pixel,
    input  wire logic                            i_cfg_we,
    input  wire logic [pem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pem_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic [pem_pkg::Q_CNT_W-1:0]     i_q_count,
    output logic                                 o_q_push,
    output pem_pkg::t_grad_item                  o_q_item
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > pem_pkg::FW_W) ? WW : pem_pkg::FW_W;
    localparam int XOW = (XW > pem_pkg::CX_W) ? XW : pem_pkg::CX_W;
    localparam int PW  = pem_pkg::PIX_W;
    localparam int SW  = PW + 2;
    localparam int YW  = pem_pkg::CY_W;
    localparam int HW  = pem_pkg::FH_W;
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);

    // configuration
    logic [pem_pkg::FW_W-1:0] r_frame_width;
    logic [HW-1:0]            r_frame_height;

    // raster position of the next pixel
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    // line stores: bank 0 holds row y-2, bank 1 holds row y-1
    logic [PW-1:0] mem_b0 [MAX_WIDTH];
    logic [PW-1:0] mem_b1 [MAX_WIDTH];
    logic [PW-1:0] r_rd0;
    logic [PW-1:0] r_rd1;

    // stage after the line store read
    logic                    r_s1_v;
    logic [XW-1:0]           r_s1_addr;
    logic [PW-1:0]           r_s1_px;
    logic                    r_s1_res;
    logic [pem_pkg::CX_W-1:0] r_s1_cx;
    logic [YW-1:0]           r_s1_cy;
    logic                    r_s1_fend;
    logic                    r_s1_fwd;
    logic [PW-1:0]           r_s1_fwd_top;
    logic [PW-1:0]           r_s1_fwd_mid;

    logic [PW-1:0] r_win [3][3];

    logic [CW-1:0]  w_eff;
    logic [CW-1:0]  fw_ext;
    logic [HW-1:0]  h_eff;
    logic [CW-1:0]  x_ext;
    logic [CW-1:0]  x_next;
    logic [HW-1:0]  y_ext;
    logic [HW-1:0]  y_next;
    logic [XOW-1:0] x_m1;
    logic           row_end;
    logic           last_row;
    logic           is_res;
    logic           is_fend;
    logic           accept;
    logic [pem_pkg::Q_CNT_W:0] occ;

    logic [PW-1:0] top_eff;
    logic [PW-1:0] mid_eff;
    logic [SW-1:0] sum_new_col;
    logic [SW-1:0] sum_old_col;
    logic [SW-1:0] sum_bot_row;
    logic [SW-1:0] sum_top_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= pem_pkg::FRAME_WIDTH_RST;
            r_frame_height <= pem_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pem_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_wdata[pem_pkg::FW_W-1:0];
            end else begin
                r_frame_height <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        fw_ext = CW'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff = CW'(1);
        end else if (fw_ext > MAXW_C) begin
            w_eff = MAXW_C;
        end else begin
            w_eff = fw_ext;
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (r_frame_height > pem_pkg::MAX_HEIGHT_C) begin
            h_eff = pem_pkg::MAX_HEIGHT_C;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // classify the incoming pixel from the current position
    always_comb begin
        x_ext    = CW'(r_col);
        x_next   = x_ext + CW'(1);
        y_ext    = HW'(r_row);
        y_next   = y_ext + HW'(1);
        row_end  = (x_next >= w_eff);
        last_row = (y_next >= h_eff);
        is_res   = (r_col >= XW'(2)) && (r_row >= YW'(2))
                   && (x_ext < w_eff) && (y_ext < h_eff);
        is_fend  = (x_next == w_eff) && (y_next == h_eff);
        x_m1     = XOW'(r_col) - XOW'(1);
    end

    assign occ    = {1'b0, i_q_count} + (pem_pkg::Q_CNT_W + 1)'(r_s1_v);
    assign o_full = (occ >= (pem_pkg::Q_CNT_W + 1)'(pem_pkg::QUEUE_DEPTH));
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : y_next[YW-1:0];
            end else begin
                r_col <= x_next[XW-1:0];
            end
        end
    end

    // the previous word writes back while this one reads: bypass same column
    assign top_eff = r_s1_fwd ? r_s1_fwd_top : r_rd0;
    assign mid_eff = r_s1_fwd ? r_s1_fwd_mid : r_rd1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd0 <= mem_b0[r_col];
            r_rd1 <= mem_b1[r_col];
        end
        if (r_s1_v) begin
            mem_b0[r_s1_addr] <= mid_eff;
            mem_b1[r_s1_addr] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr    <= r_col;
            r_s1_px      <= i_pixel;
            r_s1_res     <= is_res;
            r_s1_cx      <= x_m1[pem_pkg::CX_W-1:0];
            r_s1_cy      <= r_row - YW'(1);
            r_s1_fend    <= is_fend;
            r_s1_fwd     <= r_s1_v && (r_s1_addr == r_col);
            r_s1_fwd_top <= mid_eff;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= top_eff;
            r_win[1][2] <= mid_eff;
            r_win[2][2] <= r_s1_px;
        end
    end

    // sums over the window as it stands after this shift
    always_comb begin
        sum_new_col = SW'(top_eff) + SW'(mid_eff) + SW'(r_s1_px);
        sum_old_col = SW'(r_win[0][1]) + SW'(r_win[1][1]) + SW'(r_win[2][1]);
        sum_bot_row = SW'(r_win[2][1]) + SW'(r_win[2][2]) + SW'(r_s1_px);
        sum_top_row = SW'(r_win[0][1]) + SW'(r_win[0][2]) + SW'(top_eff);
    end

    always_comb begin
        o_q_push           = r_s1_v && r_s1_res;
        o_q_item.gx        = $signed({1'b0, sum_new_col}) - $signed({1'b0, sum_old_col});
        o_q_item.gy        = $signed({1'b0, sum_bot_row}) - $signed({1'b0, sum_top_row});
        o_q_item.center_x  = r_s1_cx;
        o_q_item.center_y  = r_s1_cy;
        o_q_item.frame_end = r_s1_fend;
    end

endmodule

`default_nettype wire

FILE: rtl/core/pem_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pem_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire pem_pkg::t_grad_item           i_q_item,
    output logic                               o_q_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [pem_pkg::EDGE_W-1:0]         o_edge_value,
    output logic [pem_pkg::CX_W-1:0]           o_center_x,
    output logic [pem_pkg::CY_W-1:0]           o_center_y,
    output logic                               o_frame_end
);

    localparam int AW  = pem_pkg::ABS_W;
    localparam int PRW = pem_pkg::ABS_W + pem_pkg::RECIP_W;
    localparam int QW  = pem_pkg::QUOT_W;
    localparam int RIW = pem_pkg::ROOT_IN_W;
    localparam int RMW = pem_pkg::REM_W;
    localparam int EW  = pem_pkg::EDGE_W;

    pem_pkg::t_back_state r_state;
    pem_pkg::t_back_state n_state;

    pem_pkg::t_grad_item         r_work;
    logic [QW-1:0]               r_qx;
    logic [QW-1:0]               r_qy;
    logic [RIW-1:0]              r_num;
    logic [RMW-1:0]              r_rem;
    logic [EW-1:0]               r_root;
    logic [pem_pkg::STEP_W-1:0]  r_step;

    logic                        r_out_v;
    logic [EW-1:0]               r_out_edge;
    logic [pem_pkg::CX_W-1:0]    r_out_cx;
    logic [pem_pkg::CY_W-1:0]    r_out_cy;
    logic                        r_out_fend;

    logic                        load_out;
    logic [pem_pkg::GRAD_W-1:0]  neg_x;
    logic [pem_pkg::GRAD_W-1:0]  neg_y;
    logic [AW-1:0]               abs_x;
    logic [AW-1:0]               abs_y;
    logic [PRW-1:0]              prod_x;
    logic [PRW-1:0]              prod_y;
    logic [pem_pkg::SQ_W-1:0]    sq_x;
    logic [pem_pkg::SQ_W-1:0]    sq_y;
    logic [RIW-1:0]              sq_sum;
    logic [RMW+1:0]              rem_sh;
    logic [RMW+1:0]              trial;
    logic                        bit_ge;
    logic [RMW+1:0]              rem_sub;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pem_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = pem_pkg::BK_DIV;
                end
            end
            pem_pkg::BK_DIV:  n_state = pem_pkg::BK_SQR;
            pem_pkg::BK_SQR:  n_state = pem_pkg::BK_ROOT;
            pem_pkg::BK_ROOT: begin
                if (r_step == pem_pkg::STEP_W'(pem_pkg::ROOT_STEPS - 1)) begin
                    n_state = pem_pkg::BK_HOLD;
                end
            end
            pem_pkg::BK_HOLD: begin
                if (!r_out_v) begin
                    n_state = pem_pkg::BK_IDLE;
                end
            end
            default: n_state = pem_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            pem_pkg::BK_IDLE: o_q_pop  = !i_q_empty;
            pem_pkg::BK_HOLD: load_out = !r_out_v;
            default: begin
                o_q_pop  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pem_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // |g| / 6 by reciprocal; sign drops out of the square
    always_comb begin
        neg_x  = -r_work.gx;
        neg_y  = -r_work.gy;
        abs_x  = r_work.gx[pem_pkg::GRAD_W-1] ? neg_x[AW-1:0] : r_work.gx[AW-1:0];
        abs_y  = r_work.gy[pem_pkg::GRAD_W-1] ? neg_y[AW-1:0] : r_work.gy[AW-1:0];
        prod_x = PRW'(abs_x) * PRW'(pem_pkg::DIV6_RECIP);
        prod_y = PRW'(abs_y) * PRW'(pem_pkg::DIV6_RECIP);
        sq_x   = pem_pkg::SQ_W'(r_qx) * pem_pkg::SQ_W'(r_qx);
        sq_y   = pem_pkg::SQ_W'(r_qy) * pem_pkg::SQ_W'(r_qy);
        sq_sum = RIW'(sq_x) + RIW'(sq_y);
    end

    // one result bit per step, two radicand bits consumed per step
    always_comb begin
        rem_sh  = {r_rem, r_num[RIW-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        bit_ge  = (rem_sh >= trial);
        rem_sub = bit_ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pem_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    r_work <= i_q_item;
                end
            end
            pem_pkg::BK_DIV: begin
                r_qx <= prod_x[pem_pkg::DIV6_SHIFT +: QW];
                r_qy <= prod_y[pem_pkg::DIV6_SHIFT +: QW];
            end
            pem_pkg::BK_SQR: begin
                r_num  <= sq_sum;
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            pem_pkg::BK_ROOT: begin
                r_num  <= {r_num[RIW-3:0], 2'b00};
                r_rem  <= rem_sub[RMW-1:0];
                r_root <= {r_root[EW-2:0], bit_ge};
                r_step <= r_step + pem_pkg::STEP_W'(1);
            end
            pem_pkg::BK_HOLD: begin
                r_num <= r_num;
            end
            default: begin
                r_num <= r_num;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load_out) begin
            r_out_v <= 1'b1;
        end else if (i_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_edge <= r_root;
            r_out_cx   <= r_work.center_x;
            r_out_cy   <= r_work.center_y;
            r_out_fend <= r_work.frame_end;
        end
    end

    assign o_empty      = !r_out_v;
    assign o_edge_value = r_out_edge;
    assign o_center_x   = r_out_cx;
    assign o_center_y   = r_out_cy;
    assign o_frame_end  = r_out_fend;

endmodule

`default_nettype wire

FILE: rtl/core/prewitt_edge_magnitude_core.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 Prewitt edge magnitude over a raster stream of 8-bit pixels. Each interior
// center gives one word: floor(sqrt((gx/6)^2 + (gy/6)^2)) with the divisions
// truncated toward zero, plus its column, row and a flag on the frame's last
// result; border centers give nothing. Frame width and height are written on the
// config port (index 0 and 1) while the block is idle; the user is bound to this,
// the block does not enforce it. The front end takes one pixel per clock whenever
// the four-entry gradient queue has room; an interior pixel then holds the back end
// for dispatch, divide, square, eight bit-serial square root steps and hand-off to
// the output register, waiting while it is full, so the square root unit paces
// interior pixels. The two line stores are MAX_WIDTH x 8 memories with no clearing
// pass; their contents after reset only feed border centers.
module prewitt_edge_magnitude_core #(
    parameter int MAX_WIDTH = pem_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [pem_pkg::PIX_W-1:0]       i_pixel,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [pem_pkg::EDGE_W-1:0]           o_edge_value,
    output logic [pem_pkg::CX_W-1:0]             o_center_x,
    output logic [pem_pkg::CY_W-1:0]             o_center_y,
    output logic                                 o_frame_end,
    input  wire logic                            i_cfg_we,
    input  wire logic [pem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pem_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic                            q_push;
    pem_pkg::t_grad_item             q_in_item;
    logic                            q_pop;
    logic                            q_empty;
    pem_pkg::t_grad_item             q_out_item;
    logic [pem_pkg::Q_CNT_W-1:0]     q_count;

    pem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    pem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item),
        .o_count (q_count)
    );

    pem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_item     (q_out_item),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_edge_value (o_edge_value),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire
